@@ src/multi_token_stream_scanner_unit_macros.svh @@
// assertion macros for the multi-token stream scanner
// define NO_ASSERTIONS to compile them out; uses the clock and reset of the includer
`ifndef MULTI_TOKEN_STREAM_SCANNER_UNIT_MACROS_SVH
`define MULTI_TOKEN_STREAM_SCANNER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define MTSS_ASSERT(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

`define MTSS_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`else

`define MTSS_ASSERT(label, expr, msg)

`define MTSS_ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

@@ src/mtss_pkg.sv @@
// shared types and constants of the multi-token stream scanner
// no dependencies
package mtss_pkg;

   localparam int NUM_SLOTS   = 4;
   localparam int SLOT_BYTES  = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_ZERO  = 3'd0,
      CSR_PATTERN_ONE   = 3'd1,
      CSR_PATTERN_TWO   = 3'd2,
      CSR_PATTERN_THREE = 3'd3,
      CSR_LENGTHS       = 3'd4,
      CSR_TOKEN_COUNT   = 3'd5,
      CSR_TOKEN_IDS     = 3'd6
   } csr_index_type;

   localparam logic [15:0] LENGTHS_RESET     = 16'h1111;
   localparam logic [2:0]  TOKEN_COUNT_RESET = 3'd1;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       last_byte;
   } req_item_type;

   typedef struct packed {
      logic        matched;
      logic [1:0]  token_index;
      logic [15:0] token_id;
   } rsp_item_type;

   typedef struct packed {
      logic [NUM_SLOTS-1:0][SLOT_BYTES-1:0][7:0] patterns;
      logic [NUM_SLOTS-1:0][3:0]                 lengths;
      logic [2:0]                                token_count;
      logic [NUM_SLOTS-1:0][15:0]                ids;
   } cfg_type;

endpackage

@@ src/mtss_stream_if.sv @@
// valid/ready stream channel with a typed payload
// no dependencies
interface mtss_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ src/mtss_csr.sv @@
// configuration registers of the stream scanner
// depends on mtss_pkg
module mtss_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [mtss_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mtss_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output mtss_pkg::cfg_type                   cfg
);
   import mtss_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_PATTERN_ZERO:  cfg_in.patterns[0] = csr_wdata;
            CSR_PATTERN_ONE:   cfg_in.patterns[1] = csr_wdata;
            CSR_PATTERN_TWO:   cfg_in.patterns[2] = csr_wdata;
            CSR_PATTERN_THREE: cfg_in.patterns[3] = csr_wdata;
            CSR_LENGTHS:       cfg_in.lengths     = csr_wdata[15:0];
            CSR_TOKEN_COUNT:   cfg_in.token_count = csr_wdata[2:0];
            CSR_TOKEN_IDS:     cfg_in.ids         = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{patterns: '0, lengths: LENGTHS_RESET,
                     token_count: TOKEN_COUNT_RESET, ids: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

@@ src/mtss_match.sv @@
// per-token compare and progress update for one text byte
// depends on mtss_pkg
module mtss_match #(
   parameter int MAX_TOKENS        = 4,
   parameter int MAX_PATTERN_BYTES = 8,
   parameter int PW                = 3
) (
   input  mtss_pkg::cfg_type                  cfg,
   input  mtss_pkg::req_item_type             item,
   input  logic [MAX_TOKENS-1:0][PW-1:0]      progress,
   output logic [MAX_TOKENS-1:0][PW-1:0]      progress_next,
   output logic                               res_valid,
   output mtss_pkg::rsp_item_type             res
);
   import mtss_pkg::*;

   logic [2:0]                    n_tokens;
   logic [MAX_TOKENS-1:0][3:0]    len;
   logic [MAX_TOKENS-1:0][PW:0]   nd;
   logic [MAX_TOKENS-1:0]         hit;
   logic [MAX_TOKENS-1:0]         enabled;
   logic [MAX_TOKENS-1:0]         done;
   logic                          found;

   // clamp token count and lengths into range
   always_comb begin
      priority if (cfg.token_count == 3'd0) begin
         n_tokens = 3'd1;
      end else if (cfg.token_count > 3'(MAX_TOKENS)) begin
         n_tokens = 3'(MAX_TOKENS);
      end else begin
         n_tokens = cfg.token_count;
      end
      for (int t = 0; t < MAX_TOKENS; t++) begin
         priority if (cfg.lengths[t] == 4'd0) begin
            len[t] = 4'd1;
         end else if (cfg.lengths[t] > 4'(MAX_PATTERN_BYTES)) begin
            len[t] = 4'(MAX_PATTERN_BYTES);
         end else begin
            len[t] = cfg.lengths[t];
         end
      end
   end

   // parallel compare, one lane per token
   always_comb begin
      for (int t = 0; t < MAX_TOKENS; t++) begin
         enabled[t] = 3'(t) < n_tokens;
         hit[t]     = item.text_byte == cfg.patterns[t][3'(progress[t])];
         nd[t]      = hit[t] ? ({1'b0, progress[t]} + 1'b1) : '0;
         done[t]    = enabled[t] && hit[t] && (4'(nd[t]) >= len[t]);
      end
   end

   // lowest completing token wins
   always_comb begin
      found = 1'b0;
      res   = '0;
      for (int t = 0; t < MAX_TOKENS; t++) begin
         if (!found && done[t]) begin
            found           = 1'b1;
            res.matched     = 1'b1;
            res.token_index = 2'(t);
            res.token_id    = cfg.ids[t];
         end
      end
      if (!found) begin
         res.token_id = cfg.ids[0];
      end
      res_valid = found || item.last_byte;
   end

   always_comb begin
      for (int t = 0; t < MAX_TOKENS; t++) begin
         if (res_valid) begin
            progress_next[t] = '0;
         end else if (enabled[t]) begin
            progress_next[t] = nd[t][PW-1:0];
         end else begin
            progress_next[t] = progress[t];
         end
      end
   end
endmodule

@@ src/multi_token_stream_scanner_unit.sv @@
// channel   dir  payload                                 handshake
// req_chan  in   text_byte[7:0], last_byte               valid / ready
// rsp_chan  out  matched, token_index[1:0], token_id[15:0]  valid / ready
// csr_*     in   csr_index[2:0], csr_wdata[63:0]         csr_wr_en, no back-pressure
// one item per cycle unless rsp stalls: input reg, one compare pass, result reg
// results go through the input and result registers; some items give none
// the match counters close a loop through the compare lanes
// synchronous reset clears counters and valids and resets config, not item regs
// a stalled result holds the pipe only once the input register is also full
// depends on mtss_pkg, mtss_stream_if, mtss_csr, mtss_match and the macros header
`include "multi_token_stream_scanner_unit_macros.svh"

module multi_token_stream_scanner_unit #(
   parameter int MAX_TOKENS        = 4,
   parameter int MAX_PATTERN_BYTES = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   mtss_stream_if.sink                       req_chan,
   mtss_stream_if.source                     rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [mtss_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mtss_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import mtss_pkg::*;

   localparam int PW = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

   cfg_type                        cfg;
   req_item_type                   req_item;

   logic                           s1_valid_ff;
   logic                           s1_valid_in;
   req_item_type                   s1_item_ff;
   logic                           out_valid_ff;
   logic                           out_valid_in;
   rsp_item_type                   out_item_ff;
   logic [MAX_TOKENS-1:0][PW-1:0]  progress_ff;
   logic [MAX_TOKENS-1:0][PW-1:0]  progress_in;

   logic                           advance;
   logic                           req_take;
   logic                           res_valid;
   rsp_item_type                   res;

   logic                           take_result;
   logic                           nomatch_bad;
   logic                           pipe_full;

   mtss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mtss_match #(
      .MAX_TOKENS        (MAX_TOKENS),
      .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
      .PW                (PW)
   ) u_match (
      .cfg           (cfg),
      .item          (s1_item_ff),
      .progress      (progress_ff),
      .progress_next (progress_in),
      .res_valid     (res_valid),
      .res           (res)
   );

   assign req_item       = req_chan.payload;
   assign advance        = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);

   always_comb begin
      priority if (advance && res_valid) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         progress_ff  <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            progress_ff <= progress_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= req_item;
      end
      if (advance && res_valid) begin
         out_item_ff <= res;
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_item_ff;

   assign take_result = advance && res_valid;
   assign nomatch_bad = out_valid_ff && !out_item_ff.matched && (out_item_ff.token_index != 2'd0);
   assign pipe_full   = s1_valid_ff && out_valid_ff && !rsp_chan.ready;

   `MTSS_ASSERT_NEXT(a_clear_on_result, take_result, progress_ff == '0, "counters not cleared")
   `MTSS_ASSERT(a_nomatch_index, !nomatch_bad, "no-match item with nonzero index")
   `MTSS_ASSERT(a_full_stall, !pipe_full || !req_chan.ready, "item taken while pipe is full")
   `MTSS_ASSERT_NEXT(a_take_fills, req_take, s1_valid_ff, "accepted item lost")
endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// self-checking testbench of the multi-token stream scanner unit
// depends on mtss_pkg, mtss_stream_if and multi_token_stream_scanner_unit
module testbench;
   import mtss_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int TARGET_ITEMS = 1700;
   localparam int HOLD_CYCLES  = 200;
   localparam int SETTLE_WAIT  = 6;
   localparam int DRAIN_LIMIT  = 5000;

   class scan_scoreboard;
      bit [63:0]    patterns[NUM_SLOTS];
      bit [15:0]    lengths;
      bit [2:0]     count;
      bit [63:0]    ids;
      bit [3:0]     progress[NUM_SLOTS];
      rsp_item_type expected_matches[$];
      int           errors;

      function new();
         foreach (patterns[i]) patterns[i] = '0;
         lengths = LENGTHS_RESET;
         count   = TOKEN_COUNT_RESET;
         ids     = '0;
         errors  = 0;
         clear_progress();
      endfunction

      function void clear_progress();
         foreach (progress[i]) progress[i] = '0;
      endfunction

      function int enabled_tokens();
         int n;
         n = int'(count);
         if (n == 0) n = 1;
         if (n > NUM_SLOTS) n = NUM_SLOTS;
         return n;
      endfunction

      function int token_length(int t);
         int l;
         l = int'(lengths[4*t +: 4]);
         if (l == 0) l = 1;
         if (l > SLOT_BYTES) l = SLOT_BYTES;
         return l;
      endfunction

      function void write_reg(csr_index_type idx, bit [63:0] value);
         case (idx)
            CSR_PATTERN_ZERO, CSR_PATTERN_ONE, CSR_PATTERN_TWO, CSR_PATTERN_THREE: begin
               patterns[idx] = value;
            end
            CSR_LENGTHS:     lengths = value[15:0];
            CSR_TOKEN_COUNT: count = value[2:0];
            CSR_TOKEN_IDS:   ids = value;
            default: ;
         endcase
      endfunction

      function void note_text_byte(req_item_type it);
         int           n;
         int           d;
         int           nd;
         bit [7:0]     pb;
         rsp_item_type r;
         n = enabled_tokens();
         for (int t = 0; t < n; t++) begin
            d  = int'(progress[t][2:0]);
            pb = patterns[t][8*d +: 8];
            nd = (it.text_byte == pb) ? d + 1 : 0;
            progress[t] = 4'(nd);
            if (nd >= token_length(t)) begin
               r.matched     = 1'b1;
               r.token_index = 2'(t);
               r.token_id    = ids[16*t +: 16];
               expected_matches = {expected_matches, r};
               clear_progress();
               return;
            end
         end
         if (it.last_byte) begin
            r.matched     = 1'b0;
            r.token_index = '0;
            r.token_id    = ids[15:0];
            expected_matches = {expected_matches, r};
            clear_progress();
         end
      endfunction

      function void check_match(rsp_item_type got);
         rsp_item_type exp;
         if (expected_matches.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual matched=%0b index=%0d id=%h",
                     $time, got.matched, got.token_index, got.token_id);
            return;
         end
         exp = expected_matches.pop_front();
         if (got.matched !== exp.matched) begin
            errors++;
            $display("%0t: matched expected %0b actual %0b", $time, exp.matched, got.matched);
         end
         if (got.token_index !== exp.token_index) begin
            errors++;
            $display("%0t: token_index expected %0d actual %0d",
                     $time, exp.token_index, got.token_index);
         end
         if (got.token_id !== exp.token_id) begin
            errors++;
            $display("%0t: token_id expected %h actual %h", $time, exp.token_id, got.token_id);
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   mtss_stream_if #(.payload_type(req_item_type)) req_chan ();
   mtss_stream_if #(.payload_type(rsp_item_type)) rsp_chan ();

   scan_scoreboard sb = new();

   int cycle_count   = 0;
   int items_sent    = 0;
   bit calm          = 1'b0;
   bit hold_request  = 1'b0;

   multi_token_stream_scanner_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) sb.note_text_byte(req_chan.payload);
         if (rsp_chan.valid && rsp_chan.ready) sb.check_match(rsp_chan.payload);
      end
   end

   function automatic int pick_gap();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // result side: random stalls, plus one long hold-off on request
   initial begin
      int stall;
      stall = 0;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            stall = HOLD_CYCLES;
         end else if (stall == 0 && !calm && $urandom_range(0, 3) == 0) begin
            stall = pick_gap();
         end
         rsp_chan.ready <= (stall == 0);
         if (stall > 0) stall--;
         @(posedge clock);
      end
   end

   task automatic send_item(input logic [7:0] text_byte, input logic last_byte);
      req_item_type it;
      int           gap;
      it.text_byte = text_byte;
      it.last_byte = last_byte;
      req_chan.valid   <= 1'b1;
      req_chan.payload <= it;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
      gap = (calm || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [63:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      csr_wr_en      <= 1'b0;
      @(posedge clock);
      while (sb.expected_matches.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   initial begin
      int         phase;
      int         nstr;
      int         kind;
      int         t;
      int         len;
      int         r;
      int         waited;
      bit         terminate;
      bit [7:0]   alpha[4];
      bit [63:0]  pat;
      bit [15:0]  lens;
      bit [2:0]   cnt;
      bit [63:0]  idv;
      bit [7:0]   text[$];

      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      csr_wr_en        <= 1'b0;
      csr_index        <= CSR_PATTERN_ZERO;
      csr_wdata        <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // defaults after reset
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b1);
      settle();

      write_csr(CSR_PATTERN_ZERO, 64'h0000_0000_0000_6261);
      write_csr(CSR_PATTERN_ONE, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(CSR_PATTERN_TWO, 64'h0);
      write_csr(CSR_PATTERN_THREE, 64'h0807_0605_0403_0201);
      write_csr(CSR_LENGTHS, 64'h80F2);
      write_csr(CSR_TOKEN_COUNT, 64'd7);
      write_csr(CSR_TOKEN_IDS, 64'hFFFF_0000_5A5A_A5A5);
      csr_wr_en <= 1'b0;
      send_item(8'h61, 1'b0);
      send_item(8'h62, 1'b0);
      // long token completes on the final byte
      for (int i = 0; i < 8; i++) send_item(8'hFF, i == 7);
      send_item(8'h00, 1'b0);
      for (int i = 1; i <= 8; i++) send_item(8'(i), i == 8);
      settle();

      // counters survive a configuration change in the middle of a string
      write_csr(CSR_TOKEN_COUNT, 64'd0);
      csr_wr_en <= 1'b0;
      send_item(8'h61, 1'b0);
      settle();
      write_csr(CSR_LENGTHS, 64'h0000);
      write_csr(CSR_TOKEN_COUNT, 64'd4);
      csr_wr_en <= 1'b0;
      send_item(8'h62, 1'b1);
      settle();

      phase = 0;
      while (items_sent < TARGET_ITEMS) begin
         foreach (alpha[i]) alpha[i] = 8'($urandom_range(0, 255));
         for (int k = 0; k < NUM_SLOTS; k++) begin
            for (int b = 0; b < SLOT_BYTES; b++) pat[8*b +: 8] = alpha[$urandom_range(0, 3)];
            write_csr(csr_index_type'(int'(CSR_PATTERN_ZERO) + k), pat);
         end
         r = $urandom_range(0, 9);
         if (r == 0) begin
            lens = 16'h0000;
         end else if (r == 1) begin
            lens = 16'hFFFF;
         end else begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
               r = $urandom_range(0, 19);
               if (r == 0) lens[4*k +: 4] = 4'd0;
               else if (r == 1) lens[4*k +: 4] = 4'($urandom_range(9, 15));
               else if (r < 14) lens[4*k +: 4] = 4'($urandom_range(1, 4));
               else lens[4*k +: 4] = 4'($urandom_range(5, 8));
            end
         end
         write_csr(CSR_LENGTHS, {48'h0, lens});
         r = $urandom_range(0, 9);
         if (r == 0) cnt = 3'd0;
         else if (r == 1) cnt = 3'($urandom_range(5, 7));
         else cnt = 3'($urandom_range(1, 4));
         write_csr(CSR_TOKEN_COUNT, {61'h0, cnt});
         r = $urandom_range(0, 9);
         if (r == 0) idv = '0;
         else if (r == 1) idv = '1;
         else idv = {$urandom, $urandom};
         write_csr(CSR_TOKEN_IDS, idv);
         csr_wr_en <= 1'b0;

         if (phase == 2) begin
            // hold results back long enough for the block to stall its input
            calm = 1'b1;
            hold_request = 1'b1;
            for (int i = 0; i < 30; i++) send_item(8'($urandom_range(0, 255)), 1'b1);
            settle();
         end

         calm = ($urandom_range(0, 3) == 0);
         nstr = $urandom_range(5, 20);
         for (int s = 0; s <= nstr; s++) begin
            text.delete();
            terminate = 1'b1;
            kind = $urandom_range(0, 99);
            t = $urandom_range(0, NUM_SLOTS - 1);
            len = sb.token_length(t);
            if (kind < 65) begin
               repeat ($urandom_range(0, 3)) text = {text, alpha[$urandom_range(0, 3)]};
               for (int b = 0; b < len; b++) text = {text, sb.patterns[t][8*b +: 8]};
               repeat ($urandom_range(0, 2)) text = {text, alpha[$urandom_range(0, 3)]};
            end else if (kind < 80) begin
               for (int b = 0; b < len - 1; b++) text = {text, sb.patterns[t][8*b +: 8]};
               text = {text, alpha[$urandom_range(0, 3)]};
               terminate = $urandom_range(0, 1);
            end else if (kind < 90) begin
               repeat ($urandom_range(1, 12)) text = {text, alpha[$urandom_range(0, 3)]};
            end else begin
               repeat ($urandom_range(1, 8)) text = {text, 8'($urandom_range(0, 255))};
            end
            // the last string of a phase is often left open
            if (s == nstr && $urandom_range(0, 9) < 3) terminate = 1'b0;
            foreach (text[i]) send_item(text[i], terminate && (i == text.size() - 1));
         end
         settle();
         calm = 1'b0;
         phase++;
      end

      req_chan.valid <= 1'b0;
      waited = 0;
      while (sb.expected_matches.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_WAIT) @(posedge clock);
      if (sb.expected_matches.size() != 0) begin
         sb.errors++;
         $display("%0t: results left over, expected 0 actual %0d",
                  $time, sb.expected_matches.size());
      end
      if (sb.errors == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
